[rtl/stable_priority_queue_top_assert.svh]
// Assertion macros shared by the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Package with shared types, codes and helpers of the stable priority queue.
package spq_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SERVE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_SERVED   = 2'd0,
		STAT_INSERTED = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [7:0]  sev;
		logic [15:0] seq;
	} entry_t;

	typedef struct packed {
		logic   have;
		entry_t ent;
	} wave_t;

	typedef struct packed {
		logic ins;
		logic shf;
	} cell_ctrl_t;

	function automatic logic goes_before(entry_t x, entry_t y);
		logic [15:0] diff;
		diff = x.seq - y.seq;
		if (x.sev != y.sev) begin
			return x.sev > y.sev;
		end
		return diff[15];
	endfunction

endpackage

[rtl/stable_priority_queue_top.sv]
// Top level of the stable priority queue: command control and the row of cells.
//
// Commands enter on the cmd channel (cmd_valid, cmd_stall, command, item_tag,
// severity); each transaction yields exactly one response transaction on the
// rsp channel (rsp_valid, rsp_stall, served_tag, status).
// Entries sit in a row of DEPTH cells in arrival order. An insert writes the
// cell at the fill position and answers in the next cycle; an insert into a full
// queue or a serve of an empty queue also answers in the next cycle.
// A serve sends a search wave through the row, one cell per cycle, which keeps
// the best entry seen so far; when the wave leaves the last cell, the winner's
// cell and every cell past it take their right neighbor's entry while the
// response is registered. Inserts are taken at one command per cycle while no
// response is stalled; a serve holds off new commands until its wave has left
// the last cell. A new command is taken while a response waits, as long as the
// response register frees up in the same cycle.
// Reset empties the queue and clears the arrival counter; cell contents are
// not cleared. While rsp_stall is high the response holds, and cmd_stall stays
// high as long as that held response is stalled.
module stable_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        command,
	input  logic [15:0] item_tag,
	input  logic [7:0]  severity,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] served_tag,
	output logic [1:0]  status
);
	import spq_pkg::*;

	`include "stable_priority_queue_top_assert.svh"

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   arr_q;
	logic          rsp_valid_q;
	logic [15:0]   served_tag_q;
	status_t       status_q;

	logic          accept;
	logic          is_ins;
	logic          full;
	logic          start;
	logic          done;
	cell_ctrl_t    ctrl;
	entry_t        new_ent;

	entry_t        ents     [DEPTH];
	entry_t        right    [DEPTH];
	logic          wv_valid [DEPTH+1];
	wave_t         wv       [DEPTH+1];
	logic [IW-1:0] wv_idx   [DEPTH+1];

	assign cmd_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign full      = cnt_q == CW'(DEPTH);
	assign is_ins    = accept && command == CMD_INSERT;
	assign start     = accept && command == CMD_SERVE && cnt_q != '0;
	assign done      = state_q == ST_SCAN && wv_valid[DEPTH];

	assign ctrl.ins    = is_ins && !full;
	assign ctrl.shf    = done;
	assign new_ent.tag = item_tag;
	assign new_ent.sev = severity;
	assign new_ent.seq = arr_q;

	assign wv_valid[0] = start;
	assign wv[0]       = '0;
	assign wv_idx[0]   = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i < DEPTH - 1) begin : g_mid
			assign right[i] = ents[i+1];
		end else begin : g_last
			assign right[i] = ents[i];
		end
		spq_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.cnt         (cnt_q),
			.sel         (wv_idx[DEPTH]),
			.new_ent     (new_ent),
			.right_ent   (right[i]),
			.wv_valid_in (wv_valid[i]),
			.wv_in       (wv[i]),
			.wv_idx_in   (wv_idx[i]),
			.ent         (ents[i]),
			.wv_valid_out(wv_valid[i+1]),
			.wv_out      (wv[i+1]),
			.wv_idx_out  (wv_idx[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			arr_q        <= '0;
			rsp_valid_q  <= 1'b0;
			served_tag_q <= '0;
			status_q     <= STAT_SERVED;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctrl.ins) begin
				cnt_q <= cnt_q + 1'b1;
				arr_q <= arr_q + 1'b1;
			end else if (done) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept && !start) begin
				rsp_valid_q <= 1'b1;
			end else if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept && !start) begin
				served_tag_q <= '0;
				if (command == CMD_SERVE) begin
					status_q <= STAT_EMPTY;
				end else if (full) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_INSERTED;
				end
			end else if (done) begin
				served_tag_q <= wv[DEPTH].ent.tag;
				status_q     <= STAT_SERVED;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign served_tag = served_tag_q;
	assign status     = status_q;

	`SPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "Entry count exceeds the depth.")
	`SPQ_ASSERT_NOW(a_wave_in_scan, wv_valid[DEPTH], state_q == ST_SCAN, "Search wave ended outside a serve.")
	`SPQ_ASSERT_NOW(a_rsp_free_scan, state_q == ST_SCAN, !rsp_valid_q, "Response pending during a serve.")
	`SPQ_ASSERT_NEXT(a_serve_dec, done, cnt_q == $past(cnt_q) - 1'b1, "Serve did not remove one entry.")

endmodule

[rtl/spq_cell.sv]
// One queue cell: holds one entry and passes the search wave to its neighbor.
module spq_cell #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int IW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic [CW-1:0]       cnt,
	input  logic [IW-1:0]       sel,
	input  spq_pkg::entry_t     new_ent,
	input  spq_pkg::entry_t     right_ent,
	input  logic                wv_valid_in,
	input  spq_pkg::wave_t      wv_in,
	input  logic [IW-1:0]       wv_idx_in,
	output spq_pkg::entry_t     ent,
	output logic                wv_valid_out,
	output spq_pkg::wave_t      wv_out,
	output logic [IW-1:0]       wv_idx_out
);
	import spq_pkg::*;

	localparam logic [CW-1:0] MY_POS = CW'(IDX);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	entry_t        ent_q;
	logic          wv_valid_q;
	wave_t         wv_q;
	logic [IW-1:0] wv_idx_q;
	logic          live;
	logic          take;

	assign live = MY_POS < cnt;
	assign take = live && (!wv_in.have || goes_before(ent_q, wv_in.ent));

	always_ff @(posedge clk) begin
		if (ctrl.ins && cnt == MY_POS) begin
			ent_q <= new_ent;
		end else if (ctrl.shf && MY_IDX >= sel) begin
			ent_q <= right_ent;
		end
		if (take) begin
			wv_q.have <= 1'b1;
			wv_q.ent  <= ent_q;
			wv_idx_q  <= MY_IDX;
		end else begin
			wv_q     <= wv_in;
			wv_idx_q <= wv_idx_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_valid_q <= 1'b0;
		end else begin
			wv_valid_q <= wv_valid_in;
		end
	end

	assign ent          = ent_q;
	assign wv_valid_out = wv_valid_q;
	assign wv_out       = wv_q;
	assign wv_idx_out   = wv_idx_q;

endmodule
